### sv/atar_pkg.sv
// Package for the axis threshold auto-repeat block: item types, config bundle, constants.
// No dependencies; used by every module of the block.
package atar_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_THRESHOLD     = 2'd0,
        CFG_INITIAL_DELAY_MS   = 2'd1,
        CFG_REPEAT_INTERVAL_MS = 2'd2
    } cfg_index_t;

    localparam logic [14:0] THRESHOLD_RST = 15'd20000;
    localparam logic [15:0] DELAY_RST     = 16'd400;
    localparam logic [15:0] INTERVAL_RST  = 16'd135;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        axis_index;
        logic signed [15:0] axis_value;
        logic [9:0]        elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic left_fire;
        logic right_fire;
        logic left_held;
        logic right_held;
    } out_item_t;

    typedef struct packed {
        logic [14:0] axis_threshold;
        logic [15:0] initial_delay_ms;
        logic [15:0] repeat_interval_ms;
    } cfg_t;

endpackage

### sv/atar_cfg_regs.sv
// Configuration register file: decodes plain writes into the three settings.
// Depends on atar_pkg.
module atar_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [atar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [atar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output atar_pkg::cfg_t                     cfg
);
    import atar_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_AXIS_THRESHOLD:     cfg_next.axis_threshold     = cfg_wdata[14:0];
                CFG_INITIAL_DELAY_MS:   cfg_next.initial_delay_ms   = cfg_wdata;
                CFG_REPEAT_INTERVAL_MS: cfg_next.repeat_interval_ms = cfg_wdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_threshold     <= THRESHOLD_RST;
            cfg_reg.initial_delay_ms   <= DELAY_RST;
            cfg_reg.repeat_interval_ms <= INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/atar_in_stage.sv
// Input register: holds one accepted item until the core consumes it.
// Depends on atar_pkg.
module atar_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  atar_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output atar_pkg::in_item_t item
);
    import atar_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // slot frees up in the same cycle the core takes it
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/atar_core.sv
// Held-flag, first-press and repeat-timer state with its single-pass update logic.
// Depends on atar_pkg.
module atar_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  atar_pkg::cfg_t      cfg,
    input  logic                advance,
    input  atar_pkg::in_item_t  item,
    output atar_pkg::out_item_t result
);
    import atar_pkg::*;

    logic signed [15:0] prev_reg, prev_next;
    logic               rpress_reg, rpress_next;
    logic               lpress_reg, lpress_next;
    logic               rfirst_reg, rfirst_next;
    logic               lfirst_reg, lfirst_next;
    logic [15:0]        timer_reg, timer_next;

    logic signed [16:0] pos;
    logic signed [16:0] neg;
    logic signed [16:0] prev_x;
    logic signed [16:0] samp_x;
    logic [16:0]        sum;
    logic [15:0]        sat;
    logic [15:0]        limit;
    logic               lfire;
    logic               rfire;

    assign pos    = signed'({2'b00, cfg.axis_threshold});
    assign neg    = -pos;
    assign prev_x = {prev_reg[15], prev_reg};
    assign samp_x = {item.axis_value[15], item.axis_value};
    assign sum    = {1'b0, timer_reg} + {7'd0, item.elapsed_ms};
    assign sat    = sum[16] ? TIMER_MAX : sum[15:0];
    assign limit  = (rfirst_reg || lfirst_reg) ? cfg.initial_delay_ms
                                               : cfg.repeat_interval_ms;

    always_comb begin
        prev_next   = prev_reg;
        rpress_next = rpress_reg;
        lpress_next = lpress_reg;
        rfirst_next = rfirst_reg;
        lfirst_next = lfirst_reg;
        timer_next  = timer_reg;
        lfire       = 1'b0;
        rfire       = 1'b0;
        if (item.kind == KIND_SAMPLE) begin
            if (item.axis_index == 8'd0) begin
                if (prev_x <= pos && samp_x > pos) begin
                    rpress_next = 1'b1;
                    rfirst_next = 1'b1;
                end
                if (prev_x > pos && samp_x <= pos) begin
                    rpress_next = 1'b0;
                    rfirst_next = 1'b0;
                end
                if (prev_x > neg && samp_x <= neg) begin
                    lpress_next = 1'b1;
                    lfirst_next = 1'b1;
                end
                if (prev_x <= neg && samp_x > neg) begin
                    lpress_next = 1'b0;
                    lfirst_next = 1'b0;
                end
                prev_next = item.axis_value;
            end
        end else if (lpress_reg || rpress_reg) begin
            timer_next = sat;
            if (sat >= limit) begin
                // left wins when both are held
                if (lpress_reg) begin
                    lfire       = 1'b1;
                    lfirst_next = 1'b0;
                end else begin
                    rfire       = 1'b1;
                    rfirst_next = 1'b0;
                end
                timer_next = 16'd0;
            end
        end else begin
            timer_next  = 16'd0;
            lfirst_next = 1'b0;
            rfirst_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            rpress_reg <= 1'b0;
            lpress_reg <= 1'b0;
            rfirst_reg <= 1'b0;
            lfirst_reg <= 1'b0;
            timer_reg  <= '0;
        end else if (advance) begin
            prev_reg   <= prev_next;
            rpress_reg <= rpress_next;
            lpress_reg <= lpress_next;
            rfirst_reg <= rfirst_next;
            lfirst_reg <= lfirst_next;
            timer_reg  <= timer_next;
        end
    end

    assign result.left_fire  = lfire;
    assign result.right_fire = rfire;
    assign result.left_held  = lpress_next;
    assign result.right_held = rpress_next;

endmodule

### sv/atar_out_stage.sv
// Result register: holds one finished item until the downstream side takes it.
// Depends on atar_pkg.
module atar_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  atar_pkg::out_item_t result,
    output logic                can_take,
    output logic                m_valid,
    input  logic                m_ready,
    output atar_pkg::out_item_t m_item
);
    import atar_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### sv/axis_threshold_auto_repeat.sv
// Top level of the axis threshold auto-repeat block.
// Depends on atar_pkg, atar_cfg_regs, atar_in_stage, atar_core, atar_out_stage.
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+-----------------------------------
//   input    | s_valid / s_ready / s_item     | kind, axis_index, axis_value, elapsed_ms
//   result   | m_valid / m_ready / m_item     | left_fire, right_fire, left/right_held
//   config   | cfg_we / cfg_index / cfg_wdata | threshold, initial delay, interval
//
// Rate: one item per cycle sustained while m_ready stays high; every input item yields exactly one result item.
// Path: an accepted item passes through the input register, then the single-pass state
//   update into the result register, whose valid flag drives m_valid.
// Reset: aresetn low clears the held flags, marks, timer and previous sample,
//   loads the settings with their defaults and empties both registers.
// Stalls: with m_ready low the result register holds its item and the input
//   register absorbs one more; s_ready drops only when both are full.
module axis_threshold_auto_repeat (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [atar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atar_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  atar_pkg::in_item_t               s_item,

    output logic                             m_valid,
    input  logic                             m_ready,
    output atar_pkg::out_item_t              m_item
);
    import atar_pkg::*;

    cfg_t      cfg;
    logic      item_valid;
    in_item_t  item;
    out_item_t result;
    logic      can_take;
    logic      advance;

    // core consumes the held item whenever the result register has room
    assign advance = item_valid && can_take;

    atar_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    atar_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // state update: crossing detect on samples, timer and fire logic on ticks
    atar_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    atar_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
